// ===== hw/rtl/gccg_pkg.sv =====
// Shared constants, types and functions for the Gold code chip generator.
package gccg_pkg;

    localparam int PERIOD_CHIPS = 1023;
    localparam int NUM_PRNS     = 8;
    localparam int ADDR_W       = $clog2(PERIOD_CHIPS);
    localparam int PRN_W        = 4;
    localparam int LFSR_W       = 10;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [PRN_W-1:0] PRN_RESET = PRN_W'(1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRN_SELECT = 1'b0,
        CFG_PHASE_OFFSET = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } code_wr_t;

    function automatic logic [LFSR_W-1:0] g2_init_word(input logic [PRN_W-1:0] prn);
        logic [LFSR_W-1:0] word;
        case (prn)
            4'd1:    word = 10'd919;
            4'd2:    word = 10'd400;
            4'd3:    word = 10'd177;
            4'd4:    word = 10'd314;
            4'd5:    word = 10'd55;
            4'd6:    word = 10'd856;
            4'd7:    word = 10'd160;
            4'd8:    word = 10'd50;
            default: word = '0;
        endcase
        return word;
    endfunction

endpackage

// ===== hw/rtl/gccg_req_if.sv =====
// Request channel carrying the restart flag.
interface gccg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// ===== hw/rtl/gccg_chip_if.sv =====
// Result channel carrying one code chip and the end-of-period flag.
interface gccg_chip_if;
    logic valid;
    logic ready;
    logic chip_bit;
    logic period_last;

    modport source (output valid, output chip_bit, output period_last, input ready);
    modport sink (input valid, input chip_bit, input period_last, output ready);
endinterface

// ===== hw/rtl/gccg_code_builder.sv =====
// Runs both LFSRs over one period and writes the chips into the code memory.
module gccg_code_builder #(
    parameter int PERIOD_CHIPS = gccg_pkg::PERIOD_CHIPS,
    parameter int NUM_PRNS     = gccg_pkg::NUM_PRNS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gccg_pkg::PRN_W-1:0]    start_prn,
    output gccg_pkg::code_wr_t            wr,
    output logic                          busy
);

    typedef enum logic [1:0] {
        BLD_IDLE = 2'b01,
        BLD_FILL = 2'b10
    } bld_state_t;

    localparam int ADDR_W = gccg_pkg::ADDR_W;
    localparam int LFSR_W = gccg_pkg::LFSR_W;

    bld_state_t              state_reg, state_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [LFSR_W-1:0]       g1_reg, g1_next;
    logic [LFSR_W-1:0]       g2_reg, g2_next;
    logic                    prn_ok_reg, prn_ok_next;
    logic                    fb1;
    logic                    fb2;
    logic                    start_ok;

    assign fb1 = g1_reg[7] ^ g1_reg[0];
    assign fb2 = g2_reg[8] ^ g2_reg[7] ^ g2_reg[4] ^ g2_reg[2] ^ g2_reg[1] ^ g2_reg[0];
    assign start_ok = (start_prn >= gccg_pkg::PRN_W'(1))
                   && (32'(start_prn) <= NUM_PRNS)
                   && (start_prn <= gccg_pkg::PRN_W'(8));

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        g1_next     = g1_reg;
        g2_next     = g2_reg;
        prn_ok_next = prn_ok_reg;
        unique case (state_reg)
            BLD_IDLE:
            begin
            end
            BLD_FILL:
            begin
                g1_next   = {fb1, g1_reg[LFSR_W-1:1]};
                g2_next   = {fb2, g2_reg[LFSR_W-1:1]};
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(PERIOD_CHIPS - 1))
                begin
                    state_next = BLD_IDLE;
                end
            end
            default:
            begin
                state_next = BLD_IDLE;
            end
        endcase
        if (start)
        begin
            state_next  = BLD_FILL;
            addr_next   = '0;
            g1_next     = '1;
            g2_next     = gccg_pkg::g2_init_word(start_prn);
            prn_ok_next = start_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BLD_FILL;
            addr_reg   <= '0;
            g1_reg     <= '1;
            g2_reg     <= gccg_pkg::g2_init_word(gccg_pkg::PRN_RESET);
            prn_ok_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            g1_reg     <= g1_next;
            g2_reg     <= g2_next;
            prn_ok_reg <= prn_ok_next;
        end
    end

    assign busy    = (state_reg != BLD_IDLE);
    assign wr.en   = (state_reg == BLD_FILL);
    assign wr.addr = addr_reg;
    assign wr.data = prn_ok_reg & (g1_reg[0] ^ g2_reg[0]);

endmodule

// ===== hw/rtl/gold_code_chip_generator.sv =====
// Top level of the Gold code chip generator: code memory, phase counter and output register.
// Each request on req (restart flag) produces exactly one result on rsp: the chip at
// position (k + code_phase_offset) mod 1023 and a flag on chip 1022 of the period.
// A restart request returns the position to 0 before its chip is produced.
// One period of chips is held in a 1023 x 1 memory with a registered read port.
// The memory is filled by a sequencer that steps both LFSRs, one chip per cycle.
// After reset and after every write of prn_select the memory is filled anew,
// during which req.ready is low; configuration writes are taken at any time.
// Once filled, the block takes one request per cycle while the receiver does not stall,
// and the result appears in the output register in the cycle after the request is taken.
// The output register is the registered read port of the memory.
// When the receiver stalls, the result waits in the output register and
// req.ready follows rsp.ready, so no result is lost or repeated.
// An invalid prn_select fills the memory with zeros, so every chip reads 0.
// Register 0 is prn_select, register 1 is code_phase_offset.
module gold_code_chip_generator #(
    parameter int PERIOD_CHIPS = gccg_pkg::PERIOD_CHIPS,
    parameter int NUM_PRNS     = gccg_pkg::NUM_PRNS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gccg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gccg_pkg::CFG_DATA_W-1:0]     cfg_data,
    gccg_req_if.sink                            req,
    gccg_chip_if.source                         rsp
);

    localparam int ADDR_W = $clog2(PERIOD_CHIPS);

    logic                        code_mem [PERIOD_CHIPS];
    gccg_pkg::code_wr_t          wr;
    logic                        busy;
    logic                        build_start;
    logic [ADDR_W-1:0]           offset_reg;
    logic [ADDR_W-1:0]           pos_reg, pos_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        chip_reg;
    logic                        last_reg;
    logic                        accept;
    logic [ADDR_W-1:0]           pos_eff;
    logic                        pos_last;
    logic [ADDR_W:0]             idx_sum;
    logic [ADDR_W-1:0]           rd_addr;

    assign build_start = cfg_we && (cfg_index == gccg_pkg::CFG_PRN_SELECT);

    gccg_code_builder #(
        .PERIOD_CHIPS (PERIOD_CHIPS),
        .NUM_PRNS     (NUM_PRNS)
    ) u_builder (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (build_start),
        .start_prn (cfg_data[gccg_pkg::PRN_W-1:0]),
        .wr        (wr),
        .busy      (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gccg_pkg::CFG_PHASE_OFFSET: offset_reg <= cfg_data[ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign req.ready = !busy && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign pos_eff  = req.restart ? '0 : pos_reg;
    assign pos_last = (pos_eff == ADDR_W'(PERIOD_CHIPS - 1));
    assign pos_next = pos_last ? '0 : pos_eff + ADDR_W'(1);
    assign idx_sum  = {1'b0, pos_eff} + {1'b0, offset_reg};
    assign rd_addr  = (idx_sum >= (ADDR_W + 1)'(PERIOD_CHIPS))
                    ? ADDR_W'(idx_sum - (ADDR_W + 1)'(PERIOD_CHIPS))
                    : idx_sum[ADDR_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // The fill and the request path never overlap, since requests are held off while busy.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            code_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chip_reg <= code_mem[rd_addr];
            last_reg <= pos_last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.chip_bit    = chip_reg;
    assign rsp.period_last = last_reg;

endmodule

// ===== tb/sv/gccg_chip_check.sv =====
// Chip predictor and result comparison for the Gold code chip generator testbench.
module gccg_chip_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gccg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gccg_pkg::CFG_DATA_W-1:0]  cfg_data,
    gccg_req_if                              req,
    gccg_chip_if                             rsp,
    output int                               mismatches,
    output int                               pending
);
    import gccg_pkg::*;

    typedef struct packed {
        logic chip_bit;
        logic period_last;
    } chip_result_t;

    localparam logic [LFSR_W-1:0] G2_SEEDS [NUM_PRNS] = '{
        10'd919, 10'd400, 10'd177, 10'd314, 10'd55, 10'd856, 10'd160, 10'd50
    };

    logic [PRN_W-1:0]        prn_sel;
    logic [CFG_DATA_W-1:0]   phase_offset;
    int                      chip_pos;
    logic [PERIOD_CHIPS-1:0] period_chips;
    chip_result_t            expected_chips[$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic logic [PERIOD_CHIPS-1:0] gold_period(input logic [PRN_W-1:0] prn);
        logic [PERIOD_CHIPS-1:0] chips;
        logic [LFSR_W-1:0]       g1;
        logic [LFSR_W-1:0]       g2;
        chips = '0;
        if (prn >= 1 && prn <= NUM_PRNS)
        begin
            g1 = '1;
            g2 = G2_SEEDS[3'(prn - 4'd1)];
            for (int k = 0; k < PERIOD_CHIPS; k++)
            begin
                chips[k] = g1[0] ^ g2[0];
                g1 = {g1[7] ^ g1[0], g1[9:1]};
                g2 = {g2[8] ^ g2[7] ^ g2[4] ^ g2[2] ^ g2[1] ^ g2[0], g2[9:1]};
            end
        end
        return chips;
    endfunction

    always @(posedge clk)
    begin
        chip_result_t want;
        chip_result_t got;
        int           idx;
        if (!rst_n)
        begin
            prn_sel      = PRN_RESET;
            phase_offset = '0;
            chip_pos     = 0;
            period_chips = gold_period(PRN_RESET);
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.chip_bit    = rsp.chip_bit;
                got.period_last = rsp.period_last;
                if (expected_chips.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected chip result: chip_bit %0b period_last %0b",
                                 got.chip_bit, got.period_last);
                end
                else
                begin
                    want = expected_chips.pop_front();
                    if (got.chip_bit !== want.chip_bit
                        || got.period_last !== want.period_last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("chip mismatch: expected %0b/%0b, got %0b/%0b %s",
                                     want.chip_bit, want.period_last,
                                     got.chip_bit, got.period_last,
                                     "(chip_bit/period_last)");
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.restart)
                    chip_pos = 0;
                idx = (chip_pos + int'(phase_offset)) % PERIOD_CHIPS;
                want.chip_bit    = period_chips[idx];
                want.period_last = (chip_pos == PERIOD_CHIPS - 1);
                expected_chips.push_back(want);
                chip_pos = (chip_pos == PERIOD_CHIPS - 1) ? 0 : chip_pos + 1;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_PRN_SELECT)
                begin
                    prn_sel      = cfg_data[PRN_W-1:0];
                    period_chips = gold_period(prn_sel);
                end
                else if (cfg_index == CFG_PHASE_OFFSET)
                    phase_offset = cfg_data;
            end
        end
        pending = expected_chips.size();
    end

endmodule

// ===== tb/sv/tb_gold_code_chip_generator.sv =====
// Testbench top for the Gold code chip generator: clock, reset, stimulus and verdict.
module tb_gold_code_chip_generator;
    import gccg_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    pending;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;

    gccg_req_if  req();
    gccg_chip_if rsp();

    gold_code_chip_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    gccg_chip_check i_chip_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("gold_code_chip_generator verification failed");
        $finish;
    end

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_index_t index, input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_request(input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid   = 1'b1;
        req.restart = restart;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_chips();
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    initial
    begin
        logic [PRN_W-1:0] prn;
        logic             restart;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_PRN_SELECT;
        cfg_data    = '0;
        req.valid   = 1'b0;
        req.restart = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: restart at the start of the period and in the middle of it.
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        repeat (3) send_request(1'b0);

        // Highest PRN and the largest offset, so the read index wraps.
        drain_chips();
        write_reg(CFG_PRN_SELECT, 10'd8);
        write_reg(CFG_PHASE_OFFSET, 10'd1022);
        send_request(1'b1);
        repeat (3) send_request(1'b0);

        // PRN zero disables the code; an offset of 1023 acts as no offset.
        drain_chips();
        write_reg(CFG_PRN_SELECT, 10'd0);
        write_reg(CFG_PHASE_OFFSET, 10'd1023);
        send_request(1'b1);
        repeat (2) send_request(1'b0);

        drain_chips();
        write_reg(CFG_PRN_SELECT, 10'h3FF);
        repeat (2) send_request(1'b0);

        drain_chips();
        write_reg(CFG_PRN_SELECT, 10'd9);
        repeat (2) send_request(1'b0);

        // Unused upper bits of the PRN write are set here.
        drain_chips();
        write_reg(CFG_PRN_SELECT, 10'h3F5);
        write_reg(CFG_PHASE_OFFSET, 10'h155);
        repeat (3) send_request(1'b0);

        // Restarts only in the first and last phases, so the middle phases
        // run through a whole period and reach its last chip.
        for (int phase = 0; phase < 6; phase++)
        begin
            drain_chips();
            if (phase < 2)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 85;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 5) == 0)
                prn = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
            else
                prn = 4'($urandom_range(1, 8));
            write_reg(CFG_PRN_SELECT, {6'($urandom), prn});
            write_reg(CFG_PHASE_OFFSET, 10'($urandom_range(0, 1023)));
            for (int i = 0; i < 260; i++)
            begin
                restart = (phase == 0 || phase == 5) && ($urandom_range(0, 23) == 0);
                send_request(restart);
            end
        end

        drain_chips();
        if (mismatches == 0 && pending == 0)
            $display("gold_code_chip_generator verification clean");
        else
            $display("gold_code_chip_generator verification failed");
        $finish;
    end

endmodule
